// File: design/pis_pkg.sv
// shared types and constants of the price indicator stream unit
package pis_pkg;

   // field widths
   localparam int PRICE_W  = 32;
   localparam int AVG_W    = 48;
   localparam int AVG_FRAC = 16;
   localparam int RSI_W    = 15;

   // stream widths
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 112;
   localparam int RSP_USER_W = 4;

   // result field positions in rsp_tdata
   localparam int SMA_S_LSB = 0;
   localparam int SMA_L_LSB = SMA_S_LSB + PRICE_W;
   localparam int RSI_LSB   = SMA_L_LSB + PRICE_W;
   localparam int VOL_LSB   = RSI_LSB + RSI_W;

   // result flag positions in rsp_tuser
   localparam int SMA_S_VLD = 0;
   localparam int SMA_L_VLD = 1;
   localparam int RSI_VLD   = 2;
   localparam int VOL_VLD   = 3;

   // serial divider sizes
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = AVG_W + 1;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // full scale of the strength index, 100 in 1/256 units
   localparam logic [RSI_W-1:0] RSI_FULL = 15'd25600;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_SCAN,
      ST_DRAIN,
      ST_SQ_MUL,
      ST_VAR,
      ST_SQRT,
      ST_OUT
   } seq_state_type;

   typedef enum logic [2:0] {
      OP_GAIN,
      OP_LOSS,
      OP_VOL,
      OP_SMA_S,
      OP_SMA_L,
      OP_RSI
   } div_op_type;

endpackage

// File: design/price_indicator_stream_unit.sv
// top level: streaming moving averages, Wilder strength index and volatility
// One price beat in, one result beat out. The shared bit-serial divider dominates the time
// of an item (up to six divisions per item; the gain and loss average divisions run only once
// the strength index is averaged, and the strength index division is skipped when the loss is
// zero); the rest is the history scan (one entry per cycle), the bit-serial squaring of the
// window sum and the bit-serial square root, plus any wait on the output register. A new price
// is taken as soon as the previous item has handed its result to the output register, even
// while that result still waits there.
module price_indicator_stream_unit #(
   parameter int SHORT_WINDOW = 5,
   parameter int LONG_WINDOW  = 10,
   parameter int RSI_PERIOD   = 14
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [31:0] close_price
   input  logic [pis_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] first_of_series
   input  logic [pis_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [31:0] short_average, [63:32] long_average, [78:64] strength_index,
   // [110:79] volatility, [111] zero
   output logic [pis_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] short_average_valid, [1] long_average_valid, [2] strength_index_valid,
   // [3] volatility_valid
   output logic [pis_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import pis_pkg::*;

   localparam int HIST_DEPTH = (SHORT_WINDOW > LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
   localparam int COUNT_CAP  = (HIST_DEPTH > RSI_PERIOD + 1) ? HIST_DEPTH : RSI_PERIOD + 1;
   localparam int CNT_W      = $clog2(COUNT_CAP + 1);
   localparam int K_W        = $clog2(HIST_DEPTH);
   localparam int SS_W       = PRICE_W + $clog2(SHORT_WINDOW);
   localparam int SL_W       = PRICE_W + $clog2(LONG_WINDOW);
   localparam int SQS_W      = 2 * PRICE_W + $clog2(LONG_WINDOW);
   localparam int ACC_W      = 2 * PRICE_W + 2 * $clog2(LONG_WINDOW);
   localparam int ROOT_W     = (ACC_W + 1) / 2;
   localparam int MUL_CNT_W  = $clog2(SL_W + 1);

   seq_state_type state_ff, state_in;
   div_op_type    op_ff;

   // item state
   logic [PRICE_W-1:0]  hist_ff [HIST_DEPTH];
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    old_cnt_ff;
   logic [PRICE_W-1:0]  prev_ff;
   logic [AVG_W-1:0]    avg_gain_ff;
   logic [AVG_W-1:0]    avg_loss_ff;
   logic [PRICE_W-1:0]  gain_ff;
   logic [PRICE_W-1:0]  loss_ff;

   // scan and squaring datapath
   logic [K_W-1:0]       k_ff;
   logic [SS_W-1:0]      sum_s_ff;
   logic [SL_W-1:0]      sum_l_ff;
   logic [2*PRICE_W-1:0] sq_ff;
   logic                 sq_v_ff;
   logic [SQS_W-1:0]     sumsq_ff;
   logic [ACC_W-1:0]     mcand_ff;
   logic [SL_W-1:0]      mplier_ff;
   logic [ACC_W-1:0]     prod_ff;
   logic [MUL_CNT_W-1:0] mul_cnt_ff;
   logic [ACC_W-1:0]     var_val;

   // quotients
   logic [PRICE_W-1:0] sma_s_q_ff;
   logic [PRICE_W-1:0] sma_l_q_ff;
   logic [PRICE_W-1:0] vol_q_ff;
   logic [RSI_W-1:0]   rsi_q_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   logic                 accept;
   logic [PRICE_W-1:0]   price;
   logic                 first;
   logic [CNT_W-1:0]     cnt_eff;
   logic [PRICE_W-1:0]   prev_eff;
   logic [AVG_W-1:0]     avg_gain_eff;
   logic [AVG_W-1:0]     avg_loss_eff;
   logic [PRICE_W-1:0]   gain_cur;
   logic [PRICE_W-1:0]   loss_cur;
   logic                 sum_phase;
   logic                 in_short;
   logic                 in_long;
   logic                 out_free;
   logic                 vld_s;
   logic                 vld_l;
   logic                 vld_r;

   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quot;
   logic                 sqrt_start;
   logic                 sqrt_done;
   logic [ROOT_W-1:0]    sqrt_root;

   // numerator of a gain or loss average update
   function automatic logic [DIV_NUM_W-1:0] avg_num(input logic [AVG_W-1:0] avg,
                                                    input logic [PRICE_W-1:0] x,
                                                    input logic seed);
      logic [AVG_W:0] total;
      total = {1'b0, avg} + (AVG_W+1)'(x);
      if (seed)
         avg_num = DIV_NUM_W'({total, {AVG_FRAC{1'b0}}});
      else
         avg_num = DIV_NUM_W'(avg) * DIV_NUM_W'(RSI_PERIOD - 1)
                 + DIV_NUM_W'({x, {AVG_FRAC{1'b0}}});
   endfunction

   // input beat and restart handling
   always_comb begin
      accept       = req_tvalid && req_tready;
      price        = req_tdata[PRICE_W-1:0];
      first        = req_tuser[0];
      cnt_eff      = first ? '0 : cnt_ff;
      prev_eff     = first ? '0 : prev_ff;
      avg_gain_eff = first ? '0 : avg_gain_ff;
      avg_loss_eff = first ? '0 : avg_loss_ff;
      gain_cur     = (price > prev_eff) ? price - prev_eff : '0;
      loss_cur     = (price > prev_eff) ? '0 : prev_eff - price;
      sum_phase    = (cnt_eff != '0) && (cnt_eff < CNT_W'(RSI_PERIOD));
      in_short     = {1'b0, k_ff} < (K_W+1)'(SHORT_WINDOW);
      in_long      = {1'b0, k_ff} < (K_W+1)'(LONG_WINDOW);
      out_free     = !rsp_valid_ff || rsp_tready;
      vld_s        = cnt_ff >= CNT_W'(SHORT_WINDOW);
      vld_l        = cnt_ff >= CNT_W'(LONG_WINDOW);
      vld_r        = cnt_ff >= CNT_W'(RSI_PERIOD + 1);
      var_val      = ACC_W'(sumsq_ff) * ACC_W'(LONG_WINDOW) - prod_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept)
               state_in = (cnt_eff >= CNT_W'(RSI_PERIOD)) ? ST_DIV_LOAD : ST_SCAN;
         end
         ST_DIV_LOAD: state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (div_done) begin
               unique case (op_ff)
                  OP_GAIN:  state_in = ST_DIV_LOAD;
                  OP_LOSS:  state_in = ST_SCAN;
                  OP_VOL:   state_in = ST_DIV_LOAD;
                  OP_SMA_S: state_in = ST_DIV_LOAD;
                  OP_SMA_L: state_in = (avg_loss_ff == '0) ? ST_OUT : ST_DIV_LOAD;
                  OP_RSI:   state_in = ST_OUT;
                  default:  state_in = ST_OUT;
               endcase
            end
         end
         ST_SCAN: begin
            if (k_ff == K_W'(HIST_DEPTH - 1))
               state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_SQ_MUL;
         ST_SQ_MUL: begin
            if (mul_cnt_ff == MUL_CNT_W'(1))
               state_in = ST_VAR;
         end
         ST_VAR: state_in = ST_SQRT;
         ST_SQRT: begin
            if (sqrt_done)
               state_in = ST_DIV_LOAD;
         end
         ST_OUT: begin
            if (out_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs and divider operand select
   always_comb begin
      req_tready = state_ff == ST_IDLE;
      div_start  = state_ff == ST_DIV_LOAD;
      sqrt_start = state_ff == ST_VAR;
      div_num    = '0;
      div_den    = DIV_DEN_W'(RSI_PERIOD);
      unique case (op_ff)
         OP_GAIN: div_num = avg_num(avg_gain_ff, gain_ff, old_cnt_ff == CNT_W'(RSI_PERIOD));
         OP_LOSS: div_num = avg_num(avg_loss_ff, loss_ff, old_cnt_ff == CNT_W'(RSI_PERIOD));
         OP_VOL: begin
            div_num = DIV_NUM_W'(sqrt_root);
            div_den = DIV_DEN_W'(LONG_WINDOW);
         end
         OP_SMA_S: begin
            div_num = DIV_NUM_W'(sum_s_ff);
            div_den = DIV_DEN_W'(SHORT_WINDOW);
         end
         OP_SMA_L: begin
            div_num = DIV_NUM_W'(sum_l_ff);
            div_den = DIV_DEN_W'(LONG_WINDOW);
         end
         OP_RSI: begin
            div_num = DIV_NUM_W'(avg_gain_ff) * DIV_NUM_W'(RSI_FULL);
            div_den = {1'b0, avg_gain_ff} + {1'b0, avg_loss_ff};
         end
         default: div_num = '0;
      endcase
   end

   // state and operation registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_GAIN;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            op_ff <= OP_GAIN;
         end else if (state_ff == ST_SQRT && sqrt_done) begin
            op_ff <= OP_VOL;
         end else if (state_ff == ST_DIV_RUN && div_done) begin
            unique case (op_ff)
               OP_GAIN:  op_ff <= OP_LOSS;
               OP_VOL:   op_ff <= OP_SMA_S;
               OP_SMA_S: op_ff <= OP_SMA_L;
               OP_SMA_L: op_ff <= OP_RSI;
               OP_LOSS:  op_ff <= OP_LOSS;
               OP_RSI:   op_ff <= OP_RSI;
               default:  op_ff <= OP_GAIN;
            endcase
         end
      end
   end

   // count, previous price and smoothed averages
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         prev_ff     <= '0;
         avg_gain_ff <= '0;
         avg_loss_ff <= '0;
      end else if (accept) begin
         cnt_ff  <= (cnt_eff < CNT_W'(COUNT_CAP)) ? cnt_eff + 1'b1 : cnt_eff;
         prev_ff <= price;
         if (sum_phase) begin
            avg_gain_ff <= avg_gain_eff + AVG_W'(gain_cur);
            avg_loss_ff <= avg_loss_eff + AVG_W'(loss_cur);
         end else begin
            avg_gain_ff <= avg_gain_eff;
            avg_loss_ff <= avg_loss_eff;
         end
      end else if (state_ff == ST_DIV_RUN && div_done) begin
         if (op_ff == OP_GAIN)
            avg_gain_ff <= div_quot[AVG_W-1:0];
         if (op_ff == OP_LOSS)
            avg_loss_ff <= div_quot[AVG_W-1:0];
      end
   end

   // per-item operands
   always_ff @(posedge clock) begin
      if (accept) begin
         old_cnt_ff <= cnt_eff;
         gain_ff    <= gain_cur;
         loss_ff    <= loss_cur;
      end
   end

   // history: shift in on a new price, rotate once around during the scan
   always_ff @(posedge clock) begin
      if (accept) begin
         hist_ff[0] <= price;
         for (int j = 1; j < HIST_DEPTH; j++)
            hist_ff[j] <= hist_ff[j-1];
      end else if (state_ff == ST_SCAN) begin
         hist_ff[HIST_DEPTH-1] <= hist_ff[0];
         for (int j = 0; j < HIST_DEPTH - 1; j++)
            hist_ff[j] <= hist_ff[j+1];
      end
   end

   // window sums and sum of squares, one entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= 1'b0;
      end else begin
         sq_v_ff <= (state_ff == ST_SCAN) && in_long;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= hist_ff[0] * hist_ff[0];
      if (accept) begin
         k_ff     <= '0;
         sum_s_ff <= '0;
         sum_l_ff <= '0;
         sumsq_ff <= '0;
      end else begin
         if (sq_v_ff)
            sumsq_ff <= sumsq_ff + SQS_W'(sq_ff);
         if (state_ff == ST_SCAN) begin
            k_ff <= k_ff + 1'b1;
            if (in_short)
               sum_s_ff <= sum_s_ff + SS_W'(hist_ff[0]);
            if (in_long)
               sum_l_ff <= sum_l_ff + SL_W'(hist_ff[0]);
         end
      end
   end

   // shift-add square of the long window sum
   always_ff @(posedge clock) begin
      if (state_ff == ST_DRAIN) begin
         mcand_ff   <= ACC_W'(sum_l_ff);
         mplier_ff  <= sum_l_ff;
         prod_ff    <= '0;
         mul_cnt_ff <= MUL_CNT_W'(SL_W);
      end else if (state_ff == ST_SQ_MUL) begin
         if (mplier_ff[0])
            prod_ff <= prod_ff + mcand_ff;
         mcand_ff   <= {mcand_ff[ACC_W-2:0], 1'b0};
         mplier_ff  <= {1'b0, mplier_ff[SL_W-1:1]};
         mul_cnt_ff <= mul_cnt_ff - 1'b1;
      end
   end

   // capture of quotients
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV_RUN && div_done) begin
         unique case (op_ff)
            OP_VOL:   vol_q_ff   <= div_quot[PRICE_W-1:0];
            OP_SMA_S: sma_s_q_ff <= div_quot[PRICE_W-1:0];
            OP_SMA_L: begin
               sma_l_q_ff <= div_quot[PRICE_W-1:0];
               rsi_q_ff   <= RSI_FULL;
            end
            OP_RSI:   rsi_q_ff   <= div_quot[RSI_W-1:0];
            OP_GAIN, OP_LOSS: ;
            default: ;
         endcase
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff <= {1'b0,
                         vld_l ? vol_q_ff : '0,
                         vld_r ? rsi_q_ff : '0,
                         vld_l ? sma_l_q_ff : '0,
                         vld_s ? sma_s_q_ff : '0};
         rsp_user_ff <= {vld_l, vld_r, vld_l, vld_s};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   pis_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   pis_sqrt #(
      .ROOT_W (ROOT_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ((2*ROOT_W)'(var_val)),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_RUN)
      else $error("divider done outside of a division step");

   // square root finishes only while the sequencer waits for it
   a_sqrt_done: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == ST_SQRT)
      else $error("square root done outside of its step");

   // sample count saturates
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(COUNT_CAP))
      else $error("sample count beyond its cap");

   // strength index stays within full scale
   a_rsi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSI_LSB +: RSI_W] <= RSI_FULL)
      else $error("strength index above full scale");

   // a short average not yet valid reads as zero
   a_sma_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[SMA_S_VLD] |-> rsp_tdata[SMA_S_LSB +: PRICE_W] == '0)
      else $error("short average not zero while invalid");

endmodule

// File: design/pis_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module pis_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pis_pkg::DIV_NUM_W-1:0] num,
   input  logic [pis_pkg::DIV_DEN_W-1:0] den,
   output logic                          done,
   output logic [pis_pkg::DIV_NUM_W-1:0] quot
);
   import pis_pkg::*;

   logic [DIV_NUM_W-1:0] num_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_DEN_W:0]   shift;
   logic [DIV_DEN_W:0]   diff;
   logic                 take;

   // trial subtract of the divisor from the shifted remainder
   always_comb begin
      shift = {rem_ff, num_ff[DIV_NUM_W-1]};
      diff  = shift - {1'b0, den_ff};
      take  = shift >= {1'b0, den_ff};
   end

   // iteration control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // dividend shifts out, quotient bits shift in
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= take ? diff[DIV_DEN_W-1:0] : shift[DIV_DEN_W-1:0];
         num_ff <= {num_ff[DIV_NUM_W-2:0], take};
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

// File: design/pis_sqrt.sv
// digit-by-digit integer square root, one root bit per cycle
module pis_sqrt #(
   parameter int ROOT_W = 36
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2*ROOT_W-1:0]   radicand,
   output logic                  done,
   output logic [ROOT_W-1:0]     root
);
   import pis_pkg::*;

   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [2*ROOT_W-1:0] rad_ff;
   logic [ROOT_W:0]     rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [ROOT_W+2:0]   rem_sh;
   logic [ROOT_W+2:0]   trial;
   logic [ROOT_W+2:0]   diff;
   logic                take;

   // bring down two radicand bits and try root*4+1
   always_comb begin
      rem_sh = {rem_ff, rad_ff[2*ROOT_W-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
      diff   = rem_sh - trial;
      take   = rem_sh >= trial;
   end

   // iteration control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ROOT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // root and remainder update
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[2*ROOT_W-3:0], 2'b00};
         rem_ff  <= take ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
         root_ff <= {root_ff[ROOT_W-2:0], take};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
